[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication checked outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication checked in and out of reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/cmg_pkg.sv]
package cmg_pkg;

    localparam int unsigned NUM_REGS    = 8;
    localparam int unsigned CFG_W       = 64;
    localparam int unsigned IDX_W       = 3;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned SLOT_W      = 16;
    localparam int unsigned OFFSET_W    = 21;
    localparam int unsigned SHIFT_W     = 5;
    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned DEF_MAX_INPUTS = 8;
    localparam int unsigned DEF_COEF_BITS  = 16;
    localparam int unsigned GAMMA_LIMIT_W  = 21;

    localparam logic [IDX_W-1:0] REG_RED_LO   = 3'd0;
    localparam logic [IDX_W-1:0] REG_RED_HI   = 3'd1;
    localparam logic [IDX_W-1:0] REG_GRN_LO   = 3'd2;
    localparam logic [IDX_W-1:0] REG_GRN_HI   = 3'd3;
    localparam logic [IDX_W-1:0] REG_BLU_LO   = 3'd4;
    localparam logic [IDX_W-1:0] REG_BLU_HI   = 3'd5;
    localparam logic [IDX_W-1:0] REG_OFFSETS  = 3'd6;
    localparam logic [IDX_W-1:0] REG_CONTROL  = 3'd7;

    // Smallest v with v^5 >= k^13, that is ceil(k^2.6), for k = 0..255.
    // Level k sits in bits k*GAMMA_LIMIT_W and up.
    function automatic logic [256*GAMMA_LIMIT_W-1:0] gamma_table();
        logic [256*GAMMA_LIMIT_W-1:0] tab;
        logic [127:0] k13;
        logic [127:0] v5;
        logic [GAMMA_LIMIT_W:0] lo;
        logic [GAMMA_LIMIT_W:0] hi;
        logic [GAMMA_LIMIT_W:0] mid;
        tab = '0;
        for (int k = 0; k < 256; k++) begin
            k13 = 128'd1;
            for (int j = 0; j < 13; j++) k13 = k13 * 128'(k);
            lo = '0;
            hi = {1'b0, {GAMMA_LIMIT_W{1'b1}}};
            for (int b = 0; b <= GAMMA_LIMIT_W; b++) begin
                if (lo < hi) begin
                    mid = (lo + hi) >> 1;
                    v5 = 128'd1;
                    for (int j = 0; j < 5; j++) v5 = v5 * 128'(mid);
                    if (v5 >= k13) hi = mid;
                    else lo = mid + 1'b1;
                end
            end
            tab[k*GAMMA_LIMIT_W +: GAMMA_LIMIT_W] = lo[GAMMA_LIMIT_W-1:0];
        end
        return tab;
    endfunction

endpackage

[src/color_matrix_gamma_pixel.sv]
// Fully pipelined color correction matrix with optional gamma, one pixel per clock.
// Stages from input accept to output valid: products, sum, shift/offset, gamma compare,
// level search into the output register; throughput one item per cycle unless stalled.
// A stall on the output holds every stage; nothing is lost or repeated.
// Reset (synchronous, active low) clears the configuration registers and the pipeline valid bits.
module color_matrix_gamma_pixel #(
    parameter int unsigned MAX_INPUTS = cmg_pkg::DEF_MAX_INPUTS,
    parameter int unsigned COEF_BITS  = cmg_pkg::DEF_COEF_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // sample_zero .. sample_seven, 16 bits each, sample_zero lowest
    input  logic [127:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // red_level [7:0], green_level [15:8], blue_level [23:16]
    output logic [23:0] m_axis_tdata
);
    `include "assert_macros.svh"

    localparam int unsigned CW    = (COEF_BITS < 16) ? COEF_BITS : 16;
    localparam int unsigned PROD_W = CW + 16;
    localparam int unsigned ACC_W  = PROD_W + 3;
    localparam int unsigned V_W    = ACC_W + 1;
    localparam int unsigned NS     = 5;
    localparam int unsigned OFFW   = cmg_pkg::OFFSET_W;
    localparam int unsigned GW     = cmg_pkg::GAMMA_LIMIT_W;
    localparam logic [256*GW-1:0] GAMMA_TAB = cmg_pkg::gamma_table();

    logic [63:0] r_coef [6];
    logic [62:0] r_offsets;
    logic [8:0]  r_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 6; j++) r_coef[j] <= '0;
            r_offsets <= '0;
            r_ctrl    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cmg_pkg::REG_RED_LO,  cmg_pkg::REG_RED_HI,
                cmg_pkg::REG_GRN_LO,  cmg_pkg::REG_GRN_HI,
                cmg_pkg::REG_BLU_LO,  cmg_pkg::REG_BLU_HI:
                    r_coef[i_cfg_idx] <= i_cfg_data;
                cmg_pkg::REG_OFFSETS: r_offsets <= i_cfg_data[62:0];
                cmg_pkg::REG_CONTROL: r_ctrl    <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    logic [3:0] count;
    always_comb begin
        count = {1'b0, r_ctrl[3:1]} + 4'd1;
        if (count > 4'(MAX_INPUTS)) count = 4'(MAX_INPUTS);
    end

    logic [NS-1:0] r_vld;
    logic          adv;
    assign adv = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = r_vld[NS-1];

    // Stage 1: products.
    logic signed [PROD_W-1:0] r_prod [3][8];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                for (int i = 0; i < 8; i++) begin
                    logic signed [CW-1:0] cf;
                    logic signed [15:0]   sm;
                    cf = r_coef[c*2 + i/4][(i%4)*16 +: CW];
                    sm = s_axis_tdata[i*16 +: 16];
                    if (i < MAX_INPUTS && 4'(i) < count)
                        r_prod[c][i] <= PROD_W'(cf * sm);
                    else
                        r_prod[c][i] <= '0;
                end
            end
        end
    end

    // Stage 2: sums.
    logic signed [ACC_W-1:0] r_acc [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                logic signed [ACC_W-1:0] s;
                s = '0;
                for (int i = 0; i < 8; i++) s = s + ACC_W'(r_prod[c][i]);
                r_acc[c] <= s;
            end
        end
    end

    // Stage 3: shift and offset.
    logic signed [V_W-1:0] r_v [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                logic signed [ACC_W-1:0]    sh;
                logic signed [OFFW-1:0]     off;
                sh  = r_acc[c] >>> r_ctrl[8:4];
                off = r_offsets[c*21 +: 21];
                r_v[c] <= V_W'(sh) + V_W'(off);
            end
        end
    end

    // Stage 4: compare against gamma thresholds (one comparator per level).
    logic [255:0] r_ge [3];
    logic [2:0]   r_neg, r_big, r_gam;
    logic [7:0]   r_lin [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                r_neg[c] <= r_v[c][V_W-1];
                r_big[c] <= (r_v[c] >= V_W'(1 << 21));
                r_lin[c] <= (r_v[c] > V_W'(255)) ? 8'd255 : r_v[c][7:0];
                for (int k = 0; k < 256; k++)
                    r_ge[c][k] <= (r_v[c] >= V_W'({1'b0, GAMMA_TAB[k*GW +: GW]}));
            end
            r_gam <= {3{r_ctrl[0]}};
        end
    end

    // Stage 5: thermometer to level, highest set bit found by binary search.
    logic [7:0] r_out [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                logic [7:0] n;
                n = '0;
                for (int b = 7; b >= 0; b--)
                    if (r_ge[c][n | (8'd1 << b)]) n = n | (8'd1 << b);
                if (r_neg[c])      r_out[c] <= 8'd0;
                else if (!r_gam[c]) r_out[c] <= r_lin[c];
                else if (r_big[c]) r_out[c] <= 8'd255;
                else               r_out[c] <= n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[NS-2:0], s_axis_tvalid};
    end

    assign m_axis_tdata = {r_out[2], r_out[1], r_out[0]};

    `ASSERT_CLK(a_ready_rule, i_clk, i_rst_n,
        s_axis_tready == (m_axis_tready || !m_axis_tvalid), "ready mismatch")
    `ASSERT_CLK(a_hold_stall, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tready) |=> $stable(r_vld), "pipeline moved on stall")
    `ASSERT_ALWAYS(a_reset_clear, i_clk,
        !i_rst_n |=> (r_vld == '0), "valid bits not cleared")
endmodule
